// ===== rtl/gpio_edge_report_and_mirror_top_macros.svh =====
// Assertion macros shared by the GPIO edge/mirror checker
`ifndef GPIO_EDGE_REPORT_AND_MIRROR_TOP_MACROS_SVH
`define GPIO_EDGE_REPORT_AND_MIRROR_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define GERM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define GERM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset
`define GERM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/germ_pkg.sv =====
// Types and constants of the GPIO edge report and mirror block
`timescale 1ns / 1ps
`default_nettype none
package germ_pkg;

  localparam int unsigned NUM_IN    = 8;
  localparam int unsigned NUM_OUT   = 16;
  localparam int unsigned TGT_W     = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Channel map: outputs first, then inputs
  localparam logic [4:0] CH_FIRST_IN  = 5'd16;
  localparam logic [4:0] CH_LAST_IN   = 5'd23;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_COLLECT = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    EDGE_OFF     = 2'd0,
    EDGE_ANY     = 2'd1,
    EDGE_RISING  = 2'd2,
    EDGE_FALLING = 2'd3
  } edge_mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_TARGET = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  input_levels;
    logic [4:0]  channel;
    logic        bit_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] output_image;
    logic        read_bit;
    logic [7:0]  changed_flags;
    logic [7:0]  reported_mask;
    logic        bad_channel;
  } out_item_t;

  typedef struct packed {
    logic [15:0] edge_mode;
    logic [7:0]  report_enable;
    logic [7:0]  mirror_enable;
    logic [31:0] mirror_target;
  } cfg_t;

  typedef struct packed {
    logic [NUM_IN-1:0]  last_levels;
    logic [NUM_IN-1:0]  change_flags;
    logic [NUM_OUT-1:0] output_levels;
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/gpio_edge_report_and_mirror_top.sv =====
// Each result beat is computed combinationally and registered in the result buffer.
// Throughput: one beat per cycle while in_stall is low; the state update is a single combinational pass.
// A two-entry result buffer keeps intake going for one beat while out_stall is high.
// in_stall rises only when both result entries are full.
// Reset (rst_n low, synchronous) clears configuration, pin state, flags and buffer.
`timescale 1ns / 1ps
`default_nettype none
module gpio_edge_report_and_mirror_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  germ_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output germ_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [germ_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [germ_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import germ_pkg::*;

  cfg_t      cfg_r;
  state_t    state_r;
  state_t    state_nxt;
  out_item_t result;
  logic      in_accept;

  assign in_accept = in_valid && !in_stall;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EDGE_MODE:     cfg_r.edge_mode     <= cfg_wdata[15:0];
        CFG_REPORT_ENABLE: cfg_r.report_enable <= cfg_wdata[7:0];
        CFG_MIRROR_ENABLE: cfg_r.mirror_enable <= cfg_wdata[7:0];
        CFG_MIRROR_TARGET: cfg_r.mirror_target <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  germ_core u_core (
    .in_item   (in_data),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Hold pin state; update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  germ_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/germ_core.sv =====
// Per-beat operation logic: sample, write, read and collect
`timescale 1ns / 1ps
`default_nettype none
module germ_core (
  input  germ_pkg::in_item_t  in_item,
  input  germ_pkg::cfg_t      cfg,
  input  germ_pkg::state_t    state,
  output germ_pkg::state_t    state_nxt,
  output germ_pkg::out_item_t result
);
  import germ_pkg::*;

  logic [NUM_IN-1:0]  diff;
  logic [NUM_IN-1:0]  mir_chg;
  logic [NUM_IN-1:0]  flag_set;
  logic [NUM_OUT-1:0] mirrored;
  logic [NUM_OUT-1:0] written;
  logic [NUM_IN-1:0]  rmask;
  logic               ch_is_out;
  logic               ch_is_in;
  op_t                op;

  assign op        = op_t'(in_item.operation);
  assign diff      = in_item.input_levels ^ state.last_levels;
  assign mir_chg   = diff & cfg.mirror_enable;
  assign ch_is_out = (in_item.channel < CH_FIRST_IN);
  assign ch_is_in  = !ch_is_out && (in_item.channel <= CH_LAST_IN);

  // Flag changed, non-mirrored inputs by their edge mode
  always_comb begin
    edge_mode_t m;
    for (int i = 0; i < NUM_IN; i++) begin
      m = edge_mode_t'(cfg.edge_mode[MODE_W*i +: MODE_W]);
      flag_set[i] = 1'b0;
      if (diff[i] && !cfg.mirror_enable[i]) begin
        unique case (m)
          EDGE_OFF:     flag_set[i] = 1'b0;
          EDGE_ANY:     flag_set[i] = 1'b1;
          EDGE_RISING:  flag_set[i] = in_item.input_levels[i];
          EDGE_FALLING: flag_set[i] = !in_item.input_levels[i];
          default:      flag_set[i] = 1'b0;
        endcase
      end
    end
  end

  // Mirror levels; the highest input wins a shared output bit
  always_comb begin
    for (int t = 0; t < NUM_OUT; t++) begin
      mirrored[t] = state.output_levels[t];
      for (int i = 0; i < NUM_IN; i++) begin
        if (mir_chg[i] && (cfg.mirror_target[TGT_W*i +: TGT_W] == TGT_W'(t))) begin
          mirrored[t] = in_item.input_levels[i];
        end
      end
    end
  end

  // Single output bit write
  always_comb begin
    written = state.output_levels;
    written[in_item.channel[3:0]] = in_item.bit_value;
  end

  assign rmask = state.change_flags & cfg.report_enable;

  // Select next state and result by operation
  always_comb begin
    state_nxt            = state;
    result.read_bit      = 1'b0;
    result.reported_mask = '0;
    result.bad_channel   = 1'b0;
    unique case (op)
      OP_SAMPLE: begin
        state_nxt.last_levels   = in_item.input_levels;
        state_nxt.change_flags  = state.change_flags | flag_set;
        state_nxt.output_levels = mirrored;
      end
      OP_WRITE: begin
        if (ch_is_out) begin
          state_nxt.output_levels = written;
        end else begin
          result.bad_channel = 1'b1;
        end
      end
      OP_READ: begin
        if (ch_is_out) begin
          result.read_bit = state.output_levels[in_item.channel[3:0]];
        end else if (ch_is_in) begin
          result.read_bit = state.last_levels[in_item.channel[2:0]];
        end else begin
          result.bad_channel = 1'b1;
        end
      end
      OP_COLLECT: begin
        result.reported_mask   = rmask;
        state_nxt.change_flags = state.change_flags & ~rmask;
      end
      default: ;
    endcase
    result.output_image  = state_nxt.output_levels;
    result.changed_flags = state_nxt.change_flags;
  end

endmodule
`default_nettype wire

// ===== rtl/germ_skid.sv =====
// Two-entry result buffer that decouples the result channel from intake
`timescale 1ns / 1ps
`default_nettype none
module germ_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_stall,
  input  germ_pkg::out_item_t push_data,
  output logic                out_valid,
  input  logic                out_stall,
  output germ_pkg::out_item_t out_data
);
  import germ_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      push;
  logic      pop;

  assign push = push_valid && !skid_valid_r;
  assign pop  = main_valid_r && !out_stall;

  // Advance the skid entry into the output slot, load a new beat into the output slot, or park a beat in the skid
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign push_stall = skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

endmodule
`default_nettype wire

// ===== rtl/germ_checker.sv =====
// Port-level checker for the GPIO edge/mirror block and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "gpio_edge_report_and_mirror_top_macros.svh"
module germ_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input germ_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input germ_pkg::out_item_t             out_data
);
  import germ_pkg::*;

  // Nothing leaves the block in the cycle after reset
  `GERM_ASSERT_ALWAYS(a_rst_idle, !rst_n, !out_valid, "result valid after reset")

  // A stalled result beat holds
  `GERM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
    "stalled result beat changed")

  // A stalled request beat holds
  `GERM_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data),
    "stalled request beat changed")

  // Collected flags are cleared in the same beat
  `GERM_ASSERT_IMP(a_collect_clear, out_valid,
    (out_data.reported_mask & out_data.changed_flags) == 8'd0,
    "collected flag still set")

  // A rejected channel reads nothing and collects nothing
  `GERM_ASSERT_IMP(a_bad_quiet, out_valid && out_data.bad_channel,
    !out_data.read_bit && (out_data.reported_mask == 8'd0),
    "bad channel beat carries data")

endmodule

bind gpio_edge_report_and_mirror_top germ_checker u_germ_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/tb_gpio_edge_report_and_mirror_top.sv =====
// Self-checking bench for the GPIO edge report and mirror block
`timescale 1ns / 1ps
module tb_gpio_edge_report_and_mirror_top;
  import germ_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 6;
  localparam int DRAIN_CYCLES = 5;

  // Tracks pin state and configuration, predicts one result beat per request beat
  class gpio_image_scoreboard;
    cfg_t      regs;
    state_t    pins;
    out_item_t expected_images[$];
    int        errors;

    function new();
      regs   = '0;
      pins   = '0;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_EDGE_MODE:     regs.edge_mode     = data[15:0];
        CFG_REPORT_ENABLE: regs.report_enable = data[7:0];
        CFG_MIRROR_ENABLE: regs.mirror_enable = data[7:0];
        CFG_MIRROR_TARGET: regs.mirror_target = data;
        default: ;
      endcase
    endfunction

    // Apply one request to the pin state and queue the result it must produce
    function void accept_request(in_item_t it);
      out_item_t  res;
      logic [7:0] diff;
      edge_mode_t mode;
      logic [3:0] tgt;
      res = '0;
      case (op_t'(it.operation))
        OP_SAMPLE: begin
          diff = it.input_levels ^ pins.last_levels;
          // Walk inputs upward so the highest mirrored input wins a shared target
          for (int i = 0; i < NUM_IN; i++) begin
            if (diff[i]) begin
              if (regs.mirror_enable[i]) begin
                tgt = regs.mirror_target[4*i +: 4];
                pins.output_levels[tgt] = it.input_levels[i];
              end else begin
                mode = edge_mode_t'(regs.edge_mode[2*i +: 2]);
                if (mode == EDGE_ANY ||
                    (mode == EDGE_RISING && it.input_levels[i]) ||
                    (mode == EDGE_FALLING && !it.input_levels[i]))
                  pins.change_flags[i] = 1'b1;
              end
            end
          end
          pins.last_levels = it.input_levels;
        end
        OP_WRITE: begin
          if (it.channel < CH_FIRST_IN) pins.output_levels[it.channel[3:0]] = it.bit_value;
          else res.bad_channel = 1'b1;
        end
        OP_READ: begin
          if (it.channel < CH_FIRST_IN) res.read_bit = pins.output_levels[it.channel[3:0]];
          else if (it.channel <= CH_LAST_IN) res.read_bit = pins.last_levels[it.channel[2:0]];
          else res.bad_channel = 1'b1;
        end
        OP_COLLECT: begin
          res.reported_mask = pins.change_flags & regs.report_enable;
          pins.change_flags = pins.change_flags & ~res.reported_mask;
        end
        default: ;
      endcase
      res.output_image  = pins.output_levels;
      res.changed_flags = pins.change_flags;
      expected_images.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp;
      if (expected_images.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp = expected_images.pop_front();
      compare_field("output_image",  exp.output_image,       got.output_image);
      compare_field("read_bit",      16'(exp.read_bit),      16'(got.read_bit));
      compare_field("changed_flags", 16'(exp.changed_flags), 16'(got.changed_flags));
      compare_field("reported_mask", 16'(exp.reported_mask), 16'(got.reported_mask));
      compare_field("bad_channel",   16'(exp.bad_channel),   16'(got.bad_channel));
    endfunction

    function int pending();
      return expected_images.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gpio_image_scoreboard sb;
  logic [7:0] levels_now = '0;
  bit         hold_req = 1'b0;
  bit         quiet = 1'b0;
  int         idle_cycles = 0;

  gpio_edge_report_and_mirror_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Check result beats and watch for a stuck handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_response(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none when quiet
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(op_t op, logic [7:0] levels, logic [4:0] ch,
                                         logic val);
    in_item_t it;
    it.operation    = op;
    it.input_levels = levels;
    it.channel      = ch;
    it.bit_value    = val;
    return it;
  endfunction

  function automatic in_item_t random_item(logic [7:0] prev);
    in_item_t it;
    it.operation = 2'($urandom_range(0, 3));
    // Mix full random levels with single-pin toggles so edges stay isolated
    if ($urandom_range(0, 1)) it.input_levels = 8'($urandom());
    else it.input_levels = prev ^ (8'd1 << $urandom_range(0, 7));
    it.channel   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                               : 5'($urandom_range(0, 23));
    it.bit_value = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one request beat and hold it until accepted
  task automatic drive_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.accept_request(it);
    if (it.operation == OP_SAMPLE) levels_now = it.input_levels;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  // Reprogram all registers once the block has gone idle
  task automatic load_config(cfg_t c);
    wait_drained();
    write_reg(CFG_EDGE_MODE,     {16'd0, c.edge_mode});
    write_reg(CFG_REPORT_ENABLE, {24'd0, c.report_enable});
    write_reg(CFG_MIRROR_ENABLE, {24'd0, c.mirror_enable});
    write_reg(CFG_MIRROR_TARGET, c.mirror_target);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t c;
    int   p;
    int   k;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset config: edges off, writes and reads at the channel boundaries
    drive_item(make_item(OP_SAMPLE,  8'hFF, 5'd0,  1'b0));
    drive_item(make_item(OP_WRITE,   8'h00, 5'd0,  1'b1));
    drive_item(make_item(OP_WRITE,   8'h00, 5'd15, 1'b1));
    drive_item(make_item(OP_WRITE,   8'h00, 5'd16, 1'b1));
    drive_item(make_item(OP_WRITE,   8'h00, 5'd31, 1'b1));
    drive_item(make_item(OP_READ,    8'h00, 5'd0,  1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd15, 1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd16, 1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd23, 1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd24, 1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd31, 1'b0));
    drive_item(make_item(OP_COLLECT, 8'h00, 5'd0,  1'b0));

    // Inputs 6 and 7 share output 3; input 3 has edges off; others flag by mode
    c.edge_mode     = {EDGE_ANY, EDGE_ANY, EDGE_FALLING, EDGE_FALLING,
                       EDGE_OFF, EDGE_RISING, EDGE_ANY, EDGE_ANY};
    c.report_enable = 8'h35;
    c.mirror_enable = 8'hC0;
    c.mirror_target = {4'd3, 4'd3, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd15};
    load_config(c);
    drive_item(make_item(OP_SAMPLE,  8'h00, 5'd0,  1'b0));
    drive_item(make_item(OP_SAMPLE,  8'hFF, 5'd0,  1'b0));
    drive_item(make_item(OP_SAMPLE,  8'h7F, 5'd0,  1'b0));
    drive_item(make_item(OP_SAMPLE,  8'hBF, 5'd0,  1'b0));
    drive_item(make_item(OP_SAMPLE,  8'h7F, 5'd0,  1'b0));
    drive_item(make_item(OP_SAMPLE,  8'h00, 5'd0,  1'b0));
    drive_item(make_item(OP_COLLECT, 8'h00, 5'd0,  1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd22, 1'b0));
    drive_item(make_item(OP_READ,    8'h00, 5'd3,  1'b0));
    drive_item(make_item(OP_COLLECT, 8'h00, 5'd0,  1'b0));

    // Random phases, each under its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: c = '1;
        2: begin
          c = {$urandom(), $urandom()};
          c.edge_mode     = {8{EDGE_ANY}};
          c.report_enable = 8'hFF;
          c.mirror_enable = 8'h00;
        end
        3: begin
          c = {$urandom(), $urandom()};
          c.edge_mode     = {8{EDGE_RISING}};
          c.mirror_enable = 8'h0F;
        end
        5: c = '0;
        default: c = {$urandom(), $urandom()};
      endcase
      load_config(c);
      quiet <= (p == NUM_PHASES - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 40) hold_req <= 1'b1;
        if (p == 2 && k == 120) wait_drained();
        if (p != NUM_PHASES - 1 && $urandom_range(0, 4) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        drive_item(random_item(levels_now));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
